/* sv/rvdec_pkg.sv */
// Package for the RV32IM instruction decoder: opcodes, funct fields,
// mnemonic and format codes. No dependencies.
package rvdec_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned REG_W  = 5;
  localparam int unsigned IMM_W  = 21;
  localparam int unsigned MNEM_W = 6;
  localparam int unsigned FMT_W  = 3;

  // Major opcodes, bits 6..0.
  localparam logic [6:0] OPC_R      = 7'h33;
  localparam logic [6:0] OPC_IALU   = 7'h13;
  localparam logic [6:0] OPC_LOAD   = 7'h03;
  localparam logic [6:0] OPC_JALR   = 7'h67;
  localparam logic [6:0] OPC_STORE  = 7'h23;
  localparam logic [6:0] OPC_BRANCH = 7'h63;
  localparam logic [6:0] OPC_LUI    = 7'h37;
  localparam logic [6:0] OPC_AUIPC  = 7'h17;
  localparam logic [6:0] OPC_JAL    = 7'h6F;
  localparam logic [6:0] OPC_SYSTEM = 7'h73;

  // funct7 classes for register-register operations.
  localparam logic [6:0] F7_BASE   = 7'h00;
  localparam logic [6:0] F7_MULDIV = 7'h01;
  localparam logic [6:0] F7_ALT    = 7'h20;

  // funct3 codes of the ALU group (the M extension reuses the same slots).
  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_SLT  = 3'd2;
  localparam logic [2:0] F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SR   = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;

  // funct3 codes of loads and stores.
  localparam logic [2:0] F3_B  = 3'd0;
  localparam logic [2:0] F3_H  = 3'd1;
  localparam logic [2:0] F3_W  = 3'd2;
  localparam logic [2:0] F3_BU = 3'd4;
  localparam logic [2:0] F3_HU = 3'd5;

  // funct3 codes of branches.
  localparam logic [2:0] F3_BEQ  = 3'd0;
  localparam logic [2:0] F3_BNE  = 3'd1;
  localparam logic [2:0] F3_BLT  = 3'd4;
  localparam logic [2:0] F3_BGE  = 3'd5;
  localparam logic [2:0] F3_BLTU = 3'd6;
  localparam logic [2:0] F3_BGEU = 3'd7;

  typedef enum logic [MNEM_W-1:0] {
    MN_ADD, MN_SUB, MN_SLL, MN_SLT, MN_SLTU, MN_XOR, MN_SRL, MN_SRA, MN_OR, MN_AND,
    MN_MUL, MN_MULH, MN_MULHU, MN_DIV, MN_DIVU, MN_REM, MN_REMU,
    MN_ADDI, MN_SLLI, MN_SLTI, MN_SLTIU, MN_XORI, MN_SRLI, MN_SRAI, MN_ORI, MN_ANDI,
    MN_LB, MN_LH, MN_LW, MN_LBU, MN_LHU, MN_JALR,
    MN_SB, MN_SH, MN_SW,
    MN_BEQ, MN_BNE, MN_BLT, MN_BGE, MN_BLTU, MN_BGEU,
    MN_LUI, MN_AUIPC, MN_JAL, MN_ECALL
  } mnem_t;

  typedef enum logic [FMT_W-1:0] {
    FMT_R, FMT_I, FMT_LOAD, FMT_STORE, FMT_BRANCH, FMT_U, FMT_JSYS
  } fmt_t;

endpackage

/* sv/rv32im_instruction_decoder.sv */
// RV32IM instruction decoder: input register, decode logic, result register.
// Depends on rvdec_pkg.
//
//   channel | ports                              | direction
//   --------+------------------------------------+----------
//   input   | in_valid, in_ready, in_instruction_word | in
//   result  | out_valid, out_ready, out_is_valid .. out_immediate | out
//
// Each accepted request is registered in the input register and then, once the result
// register can load, decoded into the result register; one request per cycle is
// sustained while the result is not stalled. The result register takes a new decode
// whenever it is empty or being drained; a stalled result holds the input register,
// and a new request is still taken while the input register is empty. Reset
// (rst_n, synchronous, low) empties both registers; the block keeps no other state.
module rv32im_instruction_decoder
  import rvdec_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [WORD_W-1:0]        in_instruction_word,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     out_is_valid,
  output logic [MNEM_W-1:0]        out_mnemonic,
  output logic [FMT_W-1:0]         out_format_kind,
  output logic [REG_W-1:0]         out_dest_reg,
  output logic [REG_W-1:0]         out_src1_reg,
  output logic [REG_W-1:0]         out_src2_reg,
  output logic signed [IMM_W-1:0]  out_immediate
);

  logic                     s1_valid_r;
  logic [WORD_W-1:0]        s1_word_r;
  logic                     out_valid_r;
  logic                     is_valid_r;
  logic [MNEM_W-1:0]        mnem_r;
  logic [FMT_W-1:0]         fmt_r;
  logic [REG_W-1:0]         rd_r;
  logic [REG_W-1:0]         rs1_r;
  logic [REG_W-1:0]         rs2_r;
  logic signed [IMM_W-1:0]  imm_r;

  logic                     out_load;
  logic                     in_accept;

  logic                     d_ok;
  mnem_t                    d_mnem;
  fmt_t                     d_fmt;
  logic [IMM_W-1:0]         d_imm;
  logic                     is_valid_nxt;
  logic [MNEM_W-1:0]        mnem_nxt;
  logic [FMT_W-1:0]         fmt_nxt;
  logic signed [IMM_W-1:0]  imm_nxt;

  logic [6:0]               opc;
  logic [2:0]               f3;
  logic [6:0]               f7;
  logic [IMM_W-1:0]         imm_i;
  logic [IMM_W-1:0]         imm_s;
  logic [IMM_W-1:0]         imm_b;
  logic [IMM_W-1:0]         imm_j;
  logic [IMM_W-1:0]         imm_u;
  logic [IMM_W-1:0]         imm_sh;

  // The input register moves on whenever the result register can load.
  assign out_load  = !out_valid_r || out_ready;
  assign in_ready  = !s1_valid_r || out_load;
  assign in_accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_accept) begin
        s1_valid_r <= 1'b1;
      end else if (out_load) begin
        s1_valid_r <= 1'b0;
      end
      if (out_load) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_word_r <= in_instruction_word;
    end
    if (out_load && s1_valid_r) begin
      is_valid_r <= is_valid_nxt;
      mnem_r     <= mnem_nxt;
      fmt_r      <= fmt_nxt;
      rd_r       <= s1_word_r[11:7];
      rs1_r      <= s1_word_r[19:15];
      rs2_r      <= s1_word_r[24:20];
      imm_r      <= imm_nxt;
    end
  end

  assign opc = s1_word_r[6:0];
  assign f3  = s1_word_r[14:12];
  assign f7  = s1_word_r[31:25];

  assign imm_i  = {{9{s1_word_r[31]}}, s1_word_r[31:20]};
  assign imm_s  = {{9{s1_word_r[31]}}, s1_word_r[31:25], s1_word_r[11:7]};
  assign imm_b  = {{8{s1_word_r[31]}}, s1_word_r[31], s1_word_r[7], s1_word_r[30:25],
                   s1_word_r[11:8], 1'b0};
  assign imm_j  = {s1_word_r[31], s1_word_r[19:12], s1_word_r[20], s1_word_r[30:21], 1'b0};
  assign imm_u  = {1'b0, s1_word_r[31:12]};
  assign imm_sh = {{(IMM_W-REG_W){1'b0}}, s1_word_r[24:20]};

  always_comb begin
    d_ok   = 1'b1;
    d_mnem = MN_ADD;
    d_fmt  = FMT_R;
    d_imm  = '0;
    unique case (opc)
      OPC_R: begin
        d_fmt = FMT_R;
        unique case (f3)
          F3_ADD: begin
            if (f7 == F7_BASE)        d_mnem = MN_ADD;
            else if (f7 == F7_MULDIV) d_mnem = MN_MUL;
            else if (f7 == F7_ALT)    d_mnem = MN_SUB;
            else                      d_ok   = 1'b0;
          end
          F3_SLL: begin
            if (f7 == F7_BASE)        d_mnem = MN_SLL;
            else if (f7 == F7_MULDIV) d_mnem = MN_MULH;
            else                      d_ok   = 1'b0;
          end
          F3_SLT: begin
            // The signed-by-unsigned high multiply is not supported.
            if (f7 == F7_BASE)        d_mnem = MN_SLT;
            else                      d_ok   = 1'b0;
          end
          F3_SLTU: begin
            if (f7 == F7_BASE)        d_mnem = MN_SLTU;
            else if (f7 == F7_MULDIV) d_mnem = MN_MULHU;
            else                      d_ok   = 1'b0;
          end
          F3_XOR: begin
            if (f7 == F7_BASE)        d_mnem = MN_XOR;
            else if (f7 == F7_MULDIV) d_mnem = MN_DIV;
            else                      d_ok   = 1'b0;
          end
          F3_SR: begin
            if (f7 == F7_BASE)        d_mnem = MN_SRL;
            else if (f7 == F7_MULDIV) d_mnem = MN_DIVU;
            else if (f7 == F7_ALT)    d_mnem = MN_SRA;
            else                      d_ok   = 1'b0;
          end
          F3_OR: begin
            if (f7 == F7_BASE)        d_mnem = MN_OR;
            else if (f7 == F7_MULDIV) d_mnem = MN_REM;
            else                      d_ok   = 1'b0;
          end
          F3_AND: begin
            if (f7 == F7_BASE)        d_mnem = MN_AND;
            else if (f7 == F7_MULDIV) d_mnem = MN_REMU;
            else                      d_ok   = 1'b0;
          end
        endcase
      end
      OPC_IALU: begin
        d_fmt = FMT_I;
        d_imm = imm_i;
        unique case (f3)
          F3_ADD:  d_mnem = MN_ADDI;
          F3_SLL:  d_mnem = MN_SLLI;
          F3_SLT:  d_mnem = MN_SLTI;
          F3_SLTU: d_mnem = MN_SLTIU;
          F3_XOR:  d_mnem = MN_XORI;
          F3_SR: begin
            // Any upper bit set selects the arithmetic shift.
            d_mnem = (f7 != F7_BASE) ? MN_SRAI : MN_SRLI;
            d_imm  = imm_sh;
          end
          F3_OR:   d_mnem = MN_ORI;
          F3_AND:  d_mnem = MN_ANDI;
        endcase
      end
      OPC_LOAD: begin
        d_fmt = FMT_LOAD;
        d_imm = imm_i;
        unique case (f3)
          F3_B:    d_mnem = MN_LB;
          F3_H:    d_mnem = MN_LH;
          F3_W:    d_mnem = MN_LW;
          F3_BU:   d_mnem = MN_LBU;
          F3_HU:   d_mnem = MN_LHU;
          default: d_ok   = 1'b0;
        endcase
      end
      OPC_JALR: begin
        d_mnem = MN_JALR;
        d_fmt  = FMT_I;
        d_imm  = imm_i;
      end
      OPC_STORE: begin
        d_fmt = FMT_STORE;
        d_imm = imm_s;
        unique case (f3)
          F3_B:    d_mnem = MN_SB;
          F3_H:    d_mnem = MN_SH;
          F3_W:    d_mnem = MN_SW;
          default: d_ok   = 1'b0;
        endcase
      end
      OPC_BRANCH: begin
        d_fmt = FMT_BRANCH;
        d_imm = imm_b;
        unique case (f3)
          F3_BEQ:  d_mnem = MN_BEQ;
          F3_BNE:  d_mnem = MN_BNE;
          F3_BLT:  d_mnem = MN_BLT;
          F3_BGE:  d_mnem = MN_BGE;
          F3_BLTU: d_mnem = MN_BLTU;
          F3_BGEU: d_mnem = MN_BGEU;
          default: d_ok   = 1'b0;
        endcase
      end
      OPC_LUI: begin
        d_mnem = MN_LUI;
        d_fmt  = FMT_U;
        d_imm  = imm_u;
      end
      OPC_AUIPC: begin
        d_mnem = MN_AUIPC;
        d_fmt  = FMT_U;
        d_imm  = imm_u;
      end
      OPC_JAL: begin
        d_mnem = MN_JAL;
        d_fmt  = FMT_JSYS;
        d_imm  = imm_j;
      end
      OPC_SYSTEM: begin
        // Every system opcode is reported as ecall.
        d_mnem = MN_ECALL;
        d_fmt  = FMT_JSYS;
      end
      default: begin
        d_ok = 1'b0;
      end
    endcase
  end

  // An unsupported word reports zero in the mnemonic, format and immediate fields.
  assign is_valid_nxt = d_ok;
  assign mnem_nxt     = d_ok ? MNEM_W'(d_mnem) : '0;
  assign fmt_nxt      = d_ok ? FMT_W'(d_fmt) : '0;
  assign imm_nxt      = d_ok ? $signed(d_imm) : '0;

  assign out_valid       = out_valid_r;
  assign out_is_valid    = is_valid_r;
  assign out_mnemonic    = mnem_r;
  assign out_format_kind = fmt_r;
  assign out_dest_reg    = rd_r;
  assign out_src1_reg    = rs1_r;
  assign out_src2_reg    = rs2_r;
  assign out_immediate   = imm_r;

`ifndef NO_ASSERTIONS
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !is_valid_r) |-> (mnem_r == '0 && fmt_r == '0 && imm_r == '0))
    else $error("unsupported word reported with non-zero decode fields");

  a_rtype_no_imm: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && is_valid_r && fmt_r == FMT_W'(FMT_R)) |-> (imm_r == '0))
    else $error("register-register operation carries an immediate");

  a_hold_stage: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !out_load) |=> (s1_valid_r && $stable(s1_word_r)))
    else $error("input register lost its request while the result stalled");

  a_take_request: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_load) |=> out_valid_r)
    else $error("request in input register did not reach the result register");
`endif

endmodule
